### rtl/ihgs_pkg.sv
// ----------------------------------------------------------------------------
// Interval heapsort greedy select package
// Shared field widths and the request, result and store entry types.
// ----------------------------------------------------------------------------
package ihgs_pkg;

  localparam int unsigned TagW  = 32;
  localparam int unsigned TimeW = 16;

  // One event request.
  typedef struct packed {
    logic [TagW-1:0]  event_tag;
    logic [TimeW-1:0] start_time;
    logic [TimeW-1:0] end_time;
    logic             batch_last;
  } evt_req_t;

  // One selected event.
  typedef struct packed {
    logic [TagW-1:0]  chosen_tag;
    logic [TimeW-1:0] chosen_start;
    logic [TimeW-1:0] chosen_end;
    logic             final_choice;
  } evt_res_t;

  // One entry of the event store: tag, start, end (end is the sort key).
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] stop;
  } entry_t;

endpackage

### rtl/interval_heapsort_greedy_select.sv
// ----------------------------------------------------------------------------
// Interval heapsort greedy select
// Collects a batch of events, heapsorts it by end time in a single memory and
// emits the greedy activity selection over the sorted list.
// ----------------------------------------------------------------------------
// Usage:
// A request (req_i) is accepted on a rising edge with start high and busy low.
// Requests without batch_last are written to the event store and
// busy stays low. Events beyond MAX_EVENTS are dropped; batch_last still
// closes the batch. The request with batch_last starts the sort and busy goes
// high until the last result has been presented.
// Results appear on result_o for exactly one cycle each, marked by
// result_valid_o, in ascending end-time order; final_choice marks the last one.
// The receiver cannot stall, so results are never held.
// A batch is processed as a heap build over the inner nodes, then repeated root
// extractions, then a selection pass over the sorted list; each sift-down level
// waits for a registered read of the single store memory.
// Reset clears the event count and the control state; the store contents are
// not cleared and only written entries are ever used.
// ----------------------------------------------------------------------------
module interval_heapsort_greedy_select #(
  parameter int unsigned MAX_EVENTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ihgs_pkg::evt_req_t req_i,
  output logic              result_valid_o,
  output ihgs_pkg::evt_res_t result_o
);

  localparam int unsigned IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_EXT_RD,
    ST_EXT_LD,
    ST_SIFT,
    ST_PUT,
    ST_SEL,
    ST_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       root_q, root_d;
  logic [IW-1:0]       hi_q, hi_d;
  logic [IW-1:0]       child_q, child_d;
  logic                extr_q, extr_d;
  ihgs_pkg::entry_t    val_q, val_d;
  logic [CW-1:0]       sel_q, sel_d;
  logic                pv_q, pv_d;
  logic                first_q, first_d;
  logic [ihgs_pkg::TimeW-1:0] lte_q, lte_d;
  ihgs_pkg::entry_t    pend_q, pend_d;
  logic                res_vld_q, res_vld_d;
  ihgs_pkg::evt_res_t  res_q, res_d;

  // Event store and its port signals.
  ihgs_pkg::entry_t    store_q [MAX_EVENTS];
  ihgs_pkg::entry_t    rd0_q, rd1_q;
  logic                mem_we;
  logic [IW-1:0]       mem_wa;
  ihgs_pkg::entry_t    mem_wd;
  logic [IW-1:0]       ra0, ra1;

  // Helper values.
  logic [CW-1:0]       n_new;
  logic [IW-1:0]       cnt_m1;
  logic                sel1, swap;
  logic [IW-1:0]       big_idx;
  ihgs_pkg::entry_t    big;
  logic [IW-1:0]       desc_root, desc_hi;
  logic [IW+1:0]       desc_c, desc_c1;
  logic                desc_ok, desc_two;
  logic                do_desc, sift_fin, sel_init;

  assign busy           = (state_q != ST_LOAD);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  assign cnt_m1 = IW'(cnt_q - CW'(1));

  // Larger child and the swap decision of the current sift-down level.
  always_comb begin
    sel1    = (child_q < hi_q) && (rd0_q.stop < rd1_q.stop);
    big_idx = sel1 ? IW'(child_q + IW'(1)) : child_q;
    big     = sel1 ? rd1_q : rd0_q;
    swap    = (val_q.stop < big.stop);
  end

  // Child addresses of the node the hole moves to next.
  always_comb begin
    case (state_q)
      ST_BLD_LD: begin
        desc_root = idx_q;
        desc_hi   = cnt_m1;
      end
      ST_EXT_LD: begin
        desc_root = '0;
        desc_hi   = IW'(idx_q - IW'(1));
      end
      default: begin
        desc_root = big_idx;
        desc_hi   = hi_q;
      end
    endcase
    desc_c   = {1'b0, desc_root, 1'b1};
    desc_c1  = desc_c + (IW+2)'(1);
    desc_ok  = (desc_c <= {2'b00, desc_hi});
    desc_two = (desc_c < {2'b00, desc_hi});
  end

  // Sequencer next-state logic and memory port control.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    root_d    = root_q;
    hi_d      = hi_q;
    child_d   = child_q;
    extr_d    = extr_q;
    val_d     = val_q;
    sel_d     = sel_q;
    pv_d      = 1'b0;
    first_d   = first_q;
    lte_d     = lte_q;
    pend_d    = pend_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wa    = root_q;
    mem_wd    = val_q;
    ra0       = '0;
    ra1       = '0;
    n_new     = cnt_q;
    do_desc   = 1'b0;
    sift_fin  = 1'b0;
    sel_init  = 1'b0;

    case (state_q)
      ST_LOAD: begin
        if (start && !busy) begin
          if (cnt_q < CW'(MAX_EVENTS)) begin
            mem_we = 1'b1;
            mem_wa = IW'(cnt_q);
            mem_wd = '{tag:   req_i.event_tag,
                       start: req_i.start_time,
                       stop:  req_i.end_time};
            n_new  = cnt_q + CW'(1);
          end
          cnt_d = n_new;
          if (req_i.batch_last) begin
            if (n_new == CW'(1)) begin
              sel_init = 1'b1;
            end else begin
              idx_d   = IW'((n_new >> 1) - CW'(1));
              extr_d  = 1'b0;
              state_d = ST_BLD_RD;
            end
          end
        end
      end
      ST_BLD_RD: begin
        ra0     = idx_q;
        state_d = ST_BLD_LD;
      end
      ST_BLD_LD: begin
        val_d   = rd0_q;
        hi_d    = cnt_m1;
        do_desc = 1'b1;
      end
      ST_EXT_RD: begin
        ra0     = '0;
        ra1     = idx_q;
        state_d = ST_EXT_LD;
      end
      ST_EXT_LD: begin
        // The old root goes to the tail; the old tail is sifted from the top.
        mem_we  = 1'b1;
        mem_wa  = idx_q;
        mem_wd  = rd0_q;
        val_d   = rd1_q;
        hi_d    = IW'(idx_q - IW'(1));
        do_desc = 1'b1;
      end
      ST_SIFT: begin
        mem_we = 1'b1;
        mem_wa = root_q;
        if (swap) begin
          mem_wd  = big;
          do_desc = 1'b1;
        end else begin
          mem_wd   = val_q;
          sift_fin = 1'b1;
        end
      end
      ST_PUT: begin
        mem_we   = 1'b1;
        mem_wa   = root_q;
        mem_wd   = val_q;
        sift_fin = 1'b1;
      end
      ST_SEL: begin
        // Stream the sorted list; hold each taken event until the next one
        // shows whether it was the final choice.
        if (sel_q < cnt_q) begin
          ra0   = IW'(sel_q);
          sel_d = sel_q + CW'(1);
          pv_d  = 1'b1;
        end else if (!pv_q) begin
          state_d = ST_FIN;
        end
        if (pv_q && (first_q || (rd0_q.start >= lte_q))) begin
          if (!first_q) begin
            res_vld_d = 1'b1;
            res_d     = '{chosen_tag:   pend_q.tag,
                          chosen_start: pend_q.start,
                          chosen_end:   pend_q.stop,
                          final_choice: 1'b0};
          end
          pend_d  = rd0_q;
          lte_d   = rd0_q.stop;
          first_d = 1'b0;
        end
      end
      ST_FIN: begin
        res_vld_d = 1'b1;
        res_d     = '{chosen_tag:   pend_q.tag,
                      chosen_start: pend_q.start,
                      chosen_end:   pend_q.stop,
                      final_choice: 1'b1};
        cnt_d     = '0;
        state_d   = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // Move the hole down one level, or place the sifted entry.
    if (do_desc) begin
      root_d = desc_root;
      if (desc_ok) begin
        ra0     = desc_c[IW-1:0];
        ra1     = desc_two ? desc_c1[IW-1:0] : desc_c[IW-1:0];
        child_d = desc_c[IW-1:0];
        state_d = ST_SIFT;
      end else begin
        state_d = ST_PUT;
      end
    end

    // One sift-down is complete: next build node, next extraction or select.
    if (sift_fin) begin
      if (!extr_q) begin
        if (idx_q == '0) begin
          extr_d  = 1'b1;
          idx_d   = cnt_m1;
          state_d = ST_EXT_RD;
        end else begin
          idx_d   = IW'(idx_q - IW'(1));
          state_d = ST_BLD_RD;
        end
      end else if (idx_q == IW'(1)) begin
        sel_init = 1'b1;
      end else begin
        idx_d   = IW'(idx_q - IW'(1));
        state_d = ST_EXT_RD;
      end
    end

    if (sel_init) begin
      sel_d   = '0;
      first_d = 1'b1;
      state_d = ST_SEL;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      idx_q     <= '0;
      root_q    <= '0;
      hi_q      <= '0;
      child_q   <= '0;
      extr_q    <= 1'b0;
      sel_q     <= '0;
      pv_q      <= 1'b0;
      first_q   <= 1'b0;
      lte_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      root_q    <= root_d;
      hi_q      <= hi_d;
      child_q   <= child_d;
      extr_q    <= extr_d;
      sel_q     <= sel_d;
      pv_q      <= pv_d;
      first_q   <= first_d;
      lte_q     <= lte_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  // Event store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_wa] <= mem_wd;
    end
    rd0_q <= store_q[ra0];
    rd1_q <= store_q[ra1];
  end

endmodule

### tb/ihgs_checker.sv
// ----------------------------------------------------------------------------
// Interval heapsort greedy select checker
// Watches the request and result channels of the block, keeps its own copy of
// the event batch, heapsorts it by end time, makes the greedy selection and
// compares every result with the oldest selection still waiting.
// ----------------------------------------------------------------------------
module ihgs_checker #(
  parameter int unsigned MaxEvents = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  ihgs_pkg::evt_req_t req_i,
  input  logic               res_valid_i,
  input  ihgs_pkg::evt_res_t res_i,
  output int                 mismatch_count_o,
  output int                 pending_o,
  output int                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  ihgs_pkg::entry_t   batch_store [MaxEvents];
  int unsigned        batch_len;
  ihgs_pkg::evt_res_t pending_choices [$];
  int                 mismatch_count = 0;
  int                 checked_count  = 0;
  int                 pending_count  = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = pending_count;
  assign checked_o        = checked_count;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Move the entry at root down the max-heap held in entries 0..hi.
  function automatic void sift_down_by_end(int root, int hi);
    int               child;
    ihgs_pkg::entry_t held;
    child = 2 * root + 1;
    while (child <= hi) begin
      if (child < hi && batch_store[child].stop < batch_store[child + 1].stop) begin
        child++;
      end
      if (batch_store[root].stop < batch_store[child].stop) begin
        held               = batch_store[root];
        batch_store[root]  = batch_store[child];
        batch_store[child] = held;
        root               = child;
        child              = 2 * root + 1;
      end else begin
        child = hi + 1;
      end
    end
  endfunction

  // Floyd heap build, then repeated root extraction: ascending by end time.
  function automatic void sort_batch_by_end(int n);
    int               i;
    ihgs_pkg::entry_t held;
    for (i = n / 2 - 1; i >= 0; i--) begin
      sift_down_by_end(i, n - 1);
    end
    for (i = n - 1; i >= 1; i--) begin
      held           = batch_store[0];
      batch_store[0] = batch_store[i];
      batch_store[i] = held;
      sift_down_by_end(0, i - 1);
    end
  endfunction

  // Take the first sorted event, then each one starting at or after the end
  // of the last one taken; the final pick carries the final mark.
  function automatic void select_greedy(int n);
    logic [ihgs_pkg::TimeW-1:0] taken_end;
    ihgs_pkg::evt_res_t         picks [$];
    ihgs_pkg::evt_res_t         pick;
    int                         i;
    for (i = 0; i < n; i++) begin
      if (i == 0 || batch_store[i].start >= taken_end) begin
        pick.chosen_tag   = batch_store[i].tag;
        pick.chosen_start = batch_store[i].start;
        pick.chosen_end   = batch_store[i].stop;
        pick.final_choice = 1'b0;
        picks.push_back(pick);
        taken_end = batch_store[i].stop;
      end
    end
    picks[picks.size() - 1].final_choice = 1'b1;
    foreach (picks[k]) begin
      pending_choices.push_back(picks[k]);
    end
  endfunction

  // Results are checked before a new request is modeled, so a batch closed
  // at this edge never lines up ahead of older selections.
  always @(posedge clk_i or negedge rst_ni) begin
    ihgs_pkg::evt_res_t want;
    if (!rst_ni) begin
      batch_len = 0;
      pending_choices.delete();
    end else begin
      if (res_valid_i) begin
        if (pending_choices.size() == 0) begin
          report_mismatch("result with no selection waiting", res_i.chosen_tag, '0);
        end else begin
          want = pending_choices.pop_front();
          checked_count++;
          if (res_i.chosen_tag !== want.chosen_tag) begin
            report_mismatch("chosen_tag", res_i.chosen_tag, want.chosen_tag);
          end
          if (res_i.chosen_start !== want.chosen_start) begin
            report_mismatch("chosen_start", 32'(res_i.chosen_start),
                            32'(want.chosen_start));
          end
          if (res_i.chosen_end !== want.chosen_end) begin
            report_mismatch("chosen_end", 32'(res_i.chosen_end), 32'(want.chosen_end));
          end
          if (res_i.final_choice !== want.final_choice) begin
            report_mismatch("final_choice", 32'(res_i.final_choice),
                            32'(want.final_choice));
          end
        end
      end

      // Requests beyond capacity are dropped, but their last mark still counts.
      if (start_i && !busy_i) begin
        if (batch_len < MaxEvents) begin
          batch_store[batch_len] = '{tag:   req_i.event_tag,
                                     start: req_i.start_time,
                                     stop:  req_i.end_time};
          batch_len++;
        end
        if (req_i.batch_last) begin
          sort_batch_by_end(batch_len);
          select_greedy(batch_len);
          batch_len = 0;
        end
      end
    end
    pending_count = pending_choices.size();
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Interval heapsort greedy select testbench
// Sends directed and random event batches with random gaps between requests;
// the checker beside the block predicts the selections and compares them.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxEvents   = 16;
  localparam int          TotalEvents = 170;
  localparam int          IdleLimit   = 4000;
  localparam int          DrainCycles = 40;

  logic               clk    = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start  = 1'b0;
  logic               busy;
  ihgs_pkg::evt_req_t req    = '0;
  logic               result_valid;
  ihgs_pkg::evt_res_t result;

  int mismatch_count;
  int pending_choices;
  int checked_choices;
  int events_sent     = 0;
  int batches_sent    = 0;
  int overfull_closed = 0;
  int idle_cycles     = 0;

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  interval_heapsort_greedy_select #(
    .MAX_EVENTS(MaxEvents)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req),
    .result_valid_o(result_valid),
    .result_o      (result)
  );

  ihgs_checker #(
    .MaxEvents(MaxEvents)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .req_i           (req),
    .res_valid_i     (result_valid),
    .res_i           (result),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_choices),
    .checked_o       (checked_choices)
  );

  // End the run if neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d idle cycles, %0d selections outstanding",
               idle_cycles, pending_choices);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold off for gap cycles, then present the request until it is taken.
  task automatic issue_event(ihgs_pkg::evt_req_t ev, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= ev;
    @(posedge clk);
    while (busy) @(posedge clk);
    events_sent++;
    if (ev.batch_last) begin
      batches_sent++;
    end
  endtask

  // Mostly short intervals around a per-batch base so that selections
  // overlap, some fully random events, and some with end times on a coarse
  // grid to force ties in the sort key.
  function automatic ihgs_pkg::evt_req_t random_event(logic [ihgs_pkg::TimeW-1:0] base);
    ihgs_pkg::evt_req_t ev;
    int                 style;
    style         = $urandom_range(0, 5);
    ev.event_tag  = $urandom;
    ev.batch_last = 1'b0;
    if (style <= 3) begin
      ev.start_time = 16'(base + $urandom_range(0, 80));
      ev.end_time   = 16'(ev.start_time + $urandom_range(0, 40));
    end else if (style == 4) begin
      ev.start_time = 16'($urandom);
      ev.end_time   = 16'($urandom);
    end else begin
      ev.start_time = 16'(base + $urandom_range(0, 40));
      ev.end_time   = 16'(base + 10 * $urandom_range(0, 3));
    end
    return ev;
  endfunction

  function automatic int draw_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 3);
  endfunction

  initial begin
    ihgs_pkg::evt_req_t         ev;
    int                         batch_size;
    int                         pick;
    bit                         steady;
    logic [ihgs_pkg::TimeW-1:0] base;

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Single-event batches at both extremes of every field.
    issue_event('{event_tag: '0, start_time: '0, end_time: '0, batch_last: 1'b1},
                draw_gap(1'b0));
    issue_event('{event_tag: '1, start_time: '1, end_time: '1, batch_last: 1'b1},
                draw_gap(1'b0));

    // Equal end times: the order among ties is whatever the heapsort leaves.
    issue_event('{event_tag: 32'h0000_0a01, start_time: 16'd0,   end_time: 16'd100,
                  batch_last: 1'b0}, draw_gap(1'b0));
    issue_event('{event_tag: 32'h0000_0a02, start_time: 16'd100, end_time: 16'd100,
                  batch_last: 1'b0}, draw_gap(1'b0));
    issue_event('{event_tag: 32'h0000_0a03, start_time: 16'd50,  end_time: 16'd100,
                  batch_last: 1'b1}, draw_gap(1'b0));

    // A full store, then a closing event that is dropped but ends the batch.
    base = 16'd1000;
    for (int i = 0; i < MaxEvents; i++) begin
      issue_event(random_event(base), 0);
    end
    issue_event('{event_tag: 32'hdead_beef, start_time: 16'd0, end_time: 16'd0,
                  batch_last: 1'b1}, 0);
    overfull_closed++;

    // Random batches, mostly small, some large up to a full store and some over capacity.
    while (events_sent < TotalEvents) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        batch_size = $urandom_range(1, 6);
      end else if (pick < 9) begin
        batch_size = $urandom_range(7, MaxEvents);
      end else begin
        batch_size = $urandom_range(MaxEvents + 1, MaxEvents + 3);
        overfull_closed++;
      end
      steady = ($urandom_range(0, 3) == 0);
      base   = 16'($urandom_range(0, 65535 - 200));
      for (int i = 0; i < batch_size; i++) begin
        ev            = random_event(base);
        ev.batch_last = (i == batch_size - 1);
        issue_event(ev, draw_gap(steady));
      end
    end
    start <= 1'b0;

    // Let the last batch finish and every selection arrive, then watch for
    // stray results.
    @(posedge clk);
    while (busy || pending_choices != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d events in %0d batches (%0d closed over capacity);",
             events_sent, batches_sent, overfull_closed);
    $display("compared %0d selected events, %0d mismatches.",
             checked_choices, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ihgs_pkg.sv
rtl/interval_heapsort_greedy_select.sv
tb/ihgs_checker.sv
tb/testbench.sv
